// ===== rtl/ddpfh_pkg.sv =====
// Shared types and constants for the DDP pixel-chain frame handler.
// No dependencies; imported by every module of the block.
package ddpfh_pkg;

   localparam int MAX_PACKET_BYTES = 1472;

   localparam int POS_W   = 11;
   localparam int PIX_W   = 9;
   localparam logic [POS_W-1:0] POS_SAT = '1;

   localparam int MIN_FRAME_BYTES = 13;
   localparam int FWD_MIN_BYTES   = 16;
   localparam int HDR_BYTES       = 8;
   localparam int OFS_FIRST       = 4;
   localparam int RED_POS         = 10;
   localparam int GREEN_POS       = 11;
   localparam int LOCAL_POS       = 12;
   localparam int PIX_BASE        = 13;
   localparam int OCTET_LIMIT     = 254;
   localparam int DEST_LIMIT      = 255;
   localparam int HDR_LEN         = 10;
   localparam int BPP             = 3;

   // x / 3 == (x * DIV3_RECIP) >> DIV3_SHIFT for x below 2048
   localparam int DIV3_RECIP = 683;
   localparam int DIV3_SHIFT = 11;

   localparam int HDR_IDX_W = 4;
   localparam int HDR_SEL_W = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam logic [1:0] CSR_OWN_OCTET  = 2'd0;
   localparam logic [1:0] CSR_LIGHT_ON   = 2'd1;
   localparam logic [1:0] CSR_BRIGHTNESS = 2'd2;

   localparam logic KIND_LOCAL = 1'b0;
   localparam logic KIND_FWD   = 1'b1;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic [POS_W-1:0] frame_len;
      logic             end_of_packet;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] fwd_byte;
      logic [7:0] fwd_dest;
      logic       fwd_first;
      logic       fwd_final;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [7:0] own_octet;
      logic       light_on;
      logic [7:0] brightness;
   } cfg_type;

   // one queued job for the back end
   typedef struct packed {
      logic       is_fwd;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] max_chan;
      logic       do_scale;
      logic [7:0] data;
      logic [7:0] dest;
      logic       first;
      logic       fin;
      logic       with_hdr;
      logic [7:0] len_byte;
   } cmd_type;

endpackage

// ===== rtl/ddpfh_front.sv =====
// Front end: byte position tracking, frame checks, header store and job classification.
// Depends on ddpfh_pkg; feeds ddpfh_queue and serves header bytes to ddpfh_back.
module ddpfh_front import ddpfh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   input  cfg_type              cfg,
   input  logic                 be_idle,
   input  logic                 q_full,
   output logic                 q_push,
   output cmd_type              q_cmd,
   input  logic [HDR_SEL_W-1:0] hdr_idx,
   output logic [7:0]           hdr_byte
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             fv_ff, fv_in;
   logic [7:0]       red_hold_ff, red_hold_in;
   logic [7:0]       green_hold_ff, green_hold_in;
   logic [PIX_W-1:0] first_px_ff, first_px_in;
   logic [PIX_W-1:0] second_px_ff, second_px_in;
   logic [7:0]       hdr_store_ff [HDR_BYTES];

   logic [POS_W-1:0] sz;
   logic [7:0]       b;
   logic             in_range, hdr_wr, accept;
   logic [POS_W-1:0] diff;
   logic [20:0]      prod3;
   logic [9:0]       p10, first10;
   logic [7:0]       mx;
   logic [POS_W-1:0] end1, len1_w, len2_w;
   logic [9:0]       dest2_w;
   logic [POS_W:0]   pos_p1;
   logic             local_go, fwd_go, in_p1, p2_ok;

   assign sz       = req_data.frame_len;
   assign b        = req_data.data_byte;
   assign in_range = pos_ff < sz;
   assign hdr_wr   = in_range && (pos_ff < POS_W'(HDR_BYTES));

   // header bytes are rewritten only once the back end has drained
   assign req_stall = q_full || (hdr_wr && !be_idle);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      fv_in = fv_ff;
      if (in_range) begin
         if (pos_ff == '0) begin
            fv_in = (sz >= POS_W'(MIN_FRAME_BYTES)) && (32'(sz) <= MAX_PACKET_BYTES);
         end
         if (pos_ff >= POS_W'(OFS_FIRST) && pos_ff < POS_W'(HDR_BYTES) && b != 8'd0) begin
            fv_in = 1'b0;
         end
      end
   end

   assign diff    = sz - POS_W'(MIN_FRAME_BYTES);
   assign prod3   = 21'(diff) * 21'(DIV3_RECIP);
   assign p10     = (sz >= POS_W'(MIN_FRAME_BYTES)) ? prod3[20:DIV3_SHIFT] : 10'd0;
   assign first10 = p10 - {1'b0, p10[9:1]};

   always_comb begin
      mx = red_hold_ff;
      if (green_hold_ff > mx) begin
         mx = green_hold_ff;
      end
      if (b > mx) begin
         mx = b;
      end
   end

   assign end1    = POS_W'(PIX_BASE) + POS_W'(first_px_ff) * POS_W'(BPP);
   assign len1_w  = POS_W'(HDR_LEN) + POS_W'(first_px_ff) * POS_W'(BPP);
   assign len2_w  = POS_W'(HDR_LEN) + POS_W'(second_px_ff) * POS_W'(BPP);
   assign dest2_w = 10'(cfg.own_octet) + 10'(first_px_ff) + 10'd1;
   assign pos_p1  = {1'b0, pos_ff} + 12'd1;

   assign local_go = in_range && (pos_ff == POS_W'(LOCAL_POS)) && fv_in;
   assign fwd_go   = in_range && (pos_ff >= POS_W'(PIX_BASE)) && fv_in
                     && (sz >= POS_W'(FWD_MIN_BYTES))
                     && (cfg.own_octet < 8'(OCTET_LIMIT));
   assign in_p1    = pos_ff < end1;
   assign p2_ok    = (second_px_ff != '0) && (dest2_w < 10'(DEST_LIMIT));

   always_comb begin
      q_cmd          = '0;
      q_cmd.red      = red_hold_ff;
      q_cmd.green    = green_hold_ff;
      q_cmd.blue     = b;
      q_cmd.max_chan = mx;
      q_cmd.do_scale = cfg.light_on && (mx != 8'd0);
      q_cmd.data     = b;
      q_cmd.is_fwd   = !local_go;
      if (in_p1) begin
         q_cmd.dest     = cfg.own_octet + 8'd1;
         q_cmd.with_hdr = pos_ff == POS_W'(PIX_BASE);
         q_cmd.first    = pos_ff == POS_W'(PIX_BASE);
         q_cmd.fin      = pos_p1 == {1'b0, end1};
         q_cmd.len_byte = len1_w[7:0];
      end else begin
         q_cmd.dest     = dest2_w[7:0];
         q_cmd.with_hdr = pos_ff == end1;
         q_cmd.first    = 1'b0;
         q_cmd.fin      = pos_p1 == {1'b0, sz};
         q_cmd.len_byte = len2_w[7:0];
      end
   end

   assign q_push = accept && (local_go || (fwd_go && (in_p1 || p2_ok)));

   always_comb begin
      pos_in        = pos_ff;
      red_hold_in   = red_hold_ff;
      green_hold_in = green_hold_ff;
      first_px_in   = first_px_ff;
      second_px_in  = second_px_ff;
      if (accept) begin
         if (req_data.end_of_packet) begin
            pos_in = '0;
         end else if (pos_ff != POS_SAT) begin
            pos_in = pos_ff + POS_W'(1);
         end
         if (in_range && pos_ff == POS_W'(RED_POS)) begin
            red_hold_in = b;
         end
         if (in_range && pos_ff == POS_W'(GREEN_POS)) begin
            green_hold_in = b;
         end
         if (local_go) begin
            second_px_in = p10[9:1];
            first_px_in  = first10[PIX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         fv_ff         <= 1'b0;
         red_hold_ff   <= '0;
         green_hold_ff <= '0;
         first_px_ff   <= '0;
         second_px_ff  <= '0;
      end else begin
         pos_ff        <= pos_in;
         fv_ff         <= accept ? fv_in : fv_ff;
         red_hold_ff   <= red_hold_in;
         green_hold_ff <= green_hold_in;
         first_px_ff   <= first_px_in;
         second_px_ff  <= second_px_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hdr_wr) begin
         hdr_store_ff[pos_ff[HDR_SEL_W-1:0]] <= b;
      end
   end

   assign hdr_byte = hdr_store_ff[hdr_idx];

endmodule

// ===== rtl/ddpfh_queue.sv =====
// Short job queue between front and back end.
// Depends on ddpfh_pkg for the job type and depth.
module ddpfh_queue import ddpfh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type din,
   input  logic    pop,
   output cmd_type dout,
   output logic    empty,
   output logic    full
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign empty   = count_ff == '0;
   assign full    = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
         rd_ptr_ff <= do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== rtl/ddpfh_back.sv =====
// Back end: colour scaling by shared multiply and shift-subtract divider, header bursts,
// and the registered result stage. Depends on ddpfh_pkg; reads jobs from ddpfh_queue.
module ddpfh_back import ddpfh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 q_empty,
   input  cmd_type              q_cmd,
   output logic                 q_pop,
   output logic [HDR_SEL_W-1:0] hdr_idx,
   input  logic [7:0]           hdr_byte,
   output logic                 be_idle,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data
);

   typedef enum logic [4:0] {
      BE_IDLE = 5'b00001,
      BE_MUL  = 5'b00010,
      BE_DIV  = 5'b00100,
      BE_HDR  = 5'b01000,
      BE_EMIT = 5'b10000
   } be_state_type;

   be_state_type         state_ff, state_in;
   cmd_type              cur_ff, cur_in;
   logic [1:0]           ch_ff, ch_in;
   logic [2:0]           step_ff, step_in;
   logic [7:0]           rem_ff, rem_in;
   logic [7:0]           quo_ff, quo_in;
   logic [HDR_IDX_W-1:0] idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic       out_free, load;
   logic [7:0] chan;
   logic [15:0] prod;
   logic [8:0] trial;
   logic       ge;
   logic [8:0] diff;
   rsp_type    beat;

   function automatic be_state_type dispatch(cmd_type c);
      be_state_type s;
      if (!c.is_fwd) begin
         s = c.do_scale ? BE_MUL : BE_EMIT;
      end else begin
         s = c.with_hdr ? BE_HDR : BE_EMIT;
      end
      return s;
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign be_idle  = state_ff == BE_IDLE;
   assign hdr_idx  = idx_ff[HDR_SEL_W-1:0];

   always_comb begin
      case (ch_ff)
         2'd0:    chan = cur_ff.red;
         2'd1:    chan = cur_ff.green;
         default: chan = cur_ff.blue;
      endcase
   end

   assign prod  = 16'(chan) * 16'(cfg.brightness);
   assign trial = {rem_ff, quo_ff[7]};
   assign ge    = trial >= {1'b0, cur_ff.max_chan};
   assign diff  = trial - {1'b0, cur_ff.max_chan};

   always_comb begin
      beat             = '0;
      beat.result_kind = KIND_FWD;
      beat.fwd_dest    = cur_ff.dest;
      if (state_ff == BE_HDR) begin
         beat.fwd_first = idx_ff == '0;
         if (idx_ff < HDR_IDX_W'(HDR_BYTES)) begin
            beat.fwd_byte = hdr_byte;
         end else if (idx_ff == HDR_IDX_W'(HDR_LEN - 1)) begin
            beat.fwd_byte = cur_ff.len_byte;
         end
      end else if (!cur_ff.is_fwd) begin
         beat.result_kind = KIND_LOCAL;
         beat.fwd_dest    = '0;
         beat.red         = cur_ff.red;
         beat.green       = cur_ff.green;
         beat.blue        = cur_ff.blue;
         beat.last_of_run = 1'b1;
      end else begin
         beat.fwd_byte    = cur_ff.data;
         beat.fwd_first   = cur_ff.first;
         beat.fwd_final   = cur_ff.fin;
         beat.last_of_run = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      ch_in    = ch_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      idx_in   = idx_ff;
      load     = 1'b0;
      q_pop    = 1'b0;
      case (state_ff)
         BE_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_cmd;
               state_in = dispatch(q_cmd);
               ch_in    = '0;
               idx_in   = '0;
            end
         end
         BE_MUL: begin
            rem_in   = prod[15:8];
            quo_in   = prod[7:0];
            step_in  = '0;
            state_in = BE_DIV;
         end
         BE_DIV: begin
            rem_in  = ge ? diff[7:0] : trial[7:0];
            quo_in  = {quo_ff[6:0], ge};
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               case (ch_ff)
                  2'd0:    cur_in.red   = quo_in;
                  2'd1:    cur_in.green = quo_in;
                  default: cur_in.blue  = quo_in;
               endcase
               if (ch_ff == 2'd2) begin
                  state_in = BE_EMIT;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = BE_MUL;
               end
            end
         end
         BE_HDR: begin
            if (out_free) begin
               load   = 1'b1;
               idx_in = idx_ff + HDR_IDX_W'(1);
               if (idx_ff == HDR_IDX_W'(HDR_LEN - 1)) begin
                  state_in = BE_EMIT;
               end
            end
         end
         BE_EMIT: begin
            if (out_free) begin
               load = 1'b1;
               if (!q_empty) begin
                  q_pop    = 1'b1;
                  cur_in   = q_cmd;
                  state_in = dispatch(q_cmd);
                  ch_in    = '0;
                  idx_in   = '0;
               end else begin
                  state_in = BE_IDLE;
               end
            end
         end
         default: state_in = BE_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = beat;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_IDLE;
         ch_ff        <= '0;
         step_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/ddp_pixel_chain_frame_handler.sv =====
// DDP pixel-chain frame handler, top level: CSRs, front end, job queue and back end.
// Depends on ddpfh_pkg, ddpfh_front, ddpfh_queue and ddpfh_back.
//
// Usage: datagram bytes arrive on req_* one beat per byte, each carrying the total
// datagram size and an end-of-packet flag. Results leave on rsp_*: one local pixel
// beat on byte 12 of a valid frame, and forwarded packet beats from byte 13 on, each
// packet opened by a ten-beat rebuilt header. last_of_run marks the last result beat
// of an input byte. The user must write CSRs (own_octet, light_on, brightness) via
// csr_we, csr_index and csr_wdata only while the block is idle; it leaves this unchecked.
// Throughput: bytes that give no result go in at one per cycle until the job queue
// (four entries) fills. A forwarded data byte gives one beat, after the header burst
// if it opens a packet. A scaled local pixel runs its three channels in turn through
// the shared 8x8 multiplier and 8-step shift-subtract divider; unscaled, it skips both.
// Header bytes 0..7 of a frame are taken only once the back end has drained, so a new
// frame may wait for the previous one's results.
// A result beat follows its byte through the job queue, back-end and output registers.
// Reset (synchronous) clears the position counter, queue, back end and output stage;
// CSRs return to own_octet 0, light off, brightness 255.
// A stall on rsp_stall holds the output register; the queue then fills and req_stall
// rises. No beat is dropped or repeated.
module ddp_pixel_chain_frame_handler import ddpfh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic                 q_push, q_pop, q_empty, q_full;
   cmd_type              q_din, q_dout;
   logic [HDR_SEL_W-1:0] hdr_idx;
   logic [7:0]           hdr_byte;
   logic                 be_idle_state, be_idle;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OWN_OCTET:  cfg_in.own_octet  = csr_wdata;
            CSR_LIGHT_ON:   cfg_in.light_on   = csr_wdata[0];
            CSR_BRIGHTNESS: cfg_in.brightness = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_octet  <= 8'd0;
         cfg_ff.light_on   <= 1'b0;
         cfg_ff.brightness <= 8'd255;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign be_idle = be_idle_state && q_empty;

   ddpfh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .be_idle   (be_idle),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_din),
      .hdr_idx   (hdr_idx),
      .hdr_byte  (hdr_byte)
   );

   ddpfh_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty),
      .full  (q_full)
   );

   ddpfh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_cmd     (q_dout),
      .q_pop     (q_pop),
      .hdr_idx   (hdr_idx),
      .hdr_byte  (hdr_byte),
      .be_idle   (be_idle_state),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into a full queue");

   a_pop_only_when_filled: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("job popped from an empty queue");

   a_local_beat_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == KIND_LOCAL) |->
         (rsp_data.last_of_run && rsp_data.fwd_byte == 8'd0 && rsp_data.fwd_dest == 8'd0
          && !rsp_data.fwd_first && !rsp_data.fwd_final))
      else $error("local pixel beat with forwarding fields set");

   a_fwd_beat_no_colour: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == KIND_FWD) |->
         (rsp_data.red == 8'd0 && rsp_data.green == 8'd0 && rsp_data.blue == 8'd0))
      else $error("forwarded beat carries colour");
`endif

endmodule
